// File: rtl/lcpr_pkg.sv
// Package for the LED channel pattern renderer: widths, types and modes.
// Used by lcpr_if, the top level and lcpr_div; depends on nothing.
package lcpr_pkg;
  localparam int NumChannels = 8;
  localparam int ChW = 3;
  localparam int ColorW = 24;
  localparam int TimeW = 16;
  localparam int MsW = 32;
  // One channel entry: color, mode, on, off, anchor.
  localparam int EntryW = ColorW + 2 + TimeW + TimeW + MsW;
  localparam logic [TimeW-1:0] FramePeriodRst = 16'd20;
  localparam logic [TimeW-1:0] PulseDefault = 16'd1000;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0, MODE_STEADY = 2'd1, MODE_BLINK = 2'd2, MODE_PULSE = 2'd3
  } mode_t;

  typedef enum logic {OP_SET = 1'b0, OP_TICK = 1'b1} op_t;

  typedef struct packed {
    logic [ColorW-1:0] color;
    mode_t             mode;
    logic [TimeW-1:0]  on_time;
    logic [TimeW-1:0]  off_time;
    logic [MsW-1:0]    anchor;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SET_RD, ST_SET_WR, ST_RD, ST_DIV, ST_PULSE, ST_DIV2,
    ST_SCALE, ST_OUT
  } state_t;

  // Divider request and reply between the sequencer and the divider.
  typedef struct packed {
    logic             start;
    logic [MsW-1:0]   num;
    logic [TimeW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MsW-1:0]   quot;
    logic [TimeW-1:0] rem;
  } div_rsp_t;
endpackage

// File: rtl/lcpr_if.sv
// Valid/ready channel interfaces for input items and rendered results.
// Depends on lcpr_pkg.
interface lcpr_in_if;
  logic                    valid;
  logic                    ready;
  lcpr_pkg::op_t           operation;
  logic [2:0]              channel;
  logic [23:0]             color;
  logic [1:0]              mode;
  logic [15:0]             on_time;
  logic [15:0]             off_time;
  modport source(output valid, operation, channel, color, mode, on_time, off_time,
                 input ready);
  modport sink(input valid, operation, channel, color, mode, on_time, off_time,
               output ready);
endinterface

interface lcpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  led_index;
  logic [23:0] led_color;
  logic        last_in_frame;
  modport source(output valid, led_index, led_color, last_in_frame, input ready);
  modport sink(input valid, led_index, led_color, last_in_frame, output ready);
endinterface

// File: rtl/led_channel_pattern_renderer_unit.sv
// Top level of the LED channel pattern renderer: sequencer around the channel RAM.
// Depends on lcpr_pkg, lcpr_if, lcpr_ram and lcpr_div.
//
//  channel | dir | handshake        | payload
//  in      | in  | in_valid/ready   | operation, channel, color, mode, on_time, off_time
//  out     | out | out_valid/ready  | led_index, led_color, last_in_frame
//  cfg     | in  | cfg_we           | cfg_wdata (frame_period)
//
// After reset the channel RAM is cleared, one entry a cycle, all 8 entries.
// A set reads the old entry and then writes the new one. A tick with no frame
// only advances the time. A frame takes each off, steady or blink channel through
// one pass of the bit-serial divider and each pulse channel through two passes.
// An output stall holds the sequencer in place.
module led_channel_pattern_renderer_unit (
  input  logic              clk,
  input  logic              rst_n,
  lcpr_in_if.sink           in_ch,
  lcpr_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata
);
  localparam int MW = lcpr_pkg::MsW;
  localparam int TW = lcpr_pkg::TimeW;

  lcpr_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]  period_cfg_r;
  logic [MW-1:0]  now_r, now_nxt, last_r, last_nxt;
  logic [2:0]     idx_r, idx_nxt;
  logic           we;
  logic [2:0]     waddr, raddr;
  lcpr_pkg::entry_t wdata, rdata;
  lcpr_pkg::entry_t ent_r, ent_nxt;
  // Captured set item.
  lcpr_pkg::entry_t set_r, set_nxt;
  logic [2:0]     set_ch_r, set_ch_nxt;
  logic [TW-1:0]  per_r, per_nxt, ph_r, ph_nxt;
  logic [7:0]     lvl_r, lvl_nxt;
  logic [23:0]    col_r, col_nxt;
  logic           ovalid_r, ovalid_nxt;
  lcpr_pkg::div_req_t dreq;
  lcpr_pkg::div_rsp_t drsp;
  logic [MW-1:0]  age, since;
  logic [TW-1:0]  half, blink_per;
  logic [TW+8:0]  pnum;
  logic [15:0]    prod_r, prod_g, prod_b;
  // The first divider pass starts in the cycle the entry arrives from the RAM.
  logic           start_r;

  lcpr_ram #(.Width(lcpr_pkg::EntryW), .Depth(lcpr_pkg::NumChannels)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  lcpr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Divide by 255 exactly for values up to 255*255.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

  always_comb begin
    age = now_r - rdata.anchor;
    since = now_r - last_r;
    half = per_r >> 1;
    blink_per = rdata.on_time + rdata.off_time;
    if (ph_r < half) pnum = {ph_r, 9'd0} - {8'd0, ph_r, 1'b0};
    else pnum = {(ph_r - half), 9'd0} - {8'd0, (ph_r - half), 1'b0};
    prod_r = col_r[23:16] * lvl_r;
    prod_g = col_r[15:8] * lvl_r;
    prod_b = col_r[7:0] * lvl_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcpr_pkg::ST_CLEAR: if (idx_r == 3'(lcpr_pkg::NumChannels - 1)) state_nxt = lcpr_pkg::ST_IDLE;
      lcpr_pkg::ST_IDLE: if (in_ch.valid) begin
        if (in_ch.operation == lcpr_pkg::OP_SET) state_nxt = lcpr_pkg::ST_SET_RD;
        else if (since + MW'(1) >= {16'd0, period_cfg_r}) state_nxt = lcpr_pkg::ST_RD;
      end
      lcpr_pkg::ST_SET_RD: state_nxt = lcpr_pkg::ST_SET_WR;
      lcpr_pkg::ST_SET_WR: state_nxt = lcpr_pkg::ST_IDLE;
      lcpr_pkg::ST_RD: state_nxt = lcpr_pkg::ST_DIV;
      lcpr_pkg::ST_DIV: if (drsp.done)
        state_nxt = (ent_r.mode == lcpr_pkg::MODE_PULSE) ? lcpr_pkg::ST_PULSE
                                                         : lcpr_pkg::ST_OUT;
      lcpr_pkg::ST_PULSE: state_nxt = lcpr_pkg::ST_DIV2;
      lcpr_pkg::ST_DIV2: if (drsp.done) state_nxt = lcpr_pkg::ST_SCALE;
      lcpr_pkg::ST_SCALE: state_nxt = lcpr_pkg::ST_OUT;
      lcpr_pkg::ST_OUT: if (ovalid_r && out_ch.ready)
        state_nxt = (idx_r == 3'(lcpr_pkg::NumChannels - 1)) ? lcpr_pkg::ST_IDLE
                                                              : lcpr_pkg::ST_RD;
      default: state_nxt = lcpr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    now_nxt = now_r;
    last_nxt = last_r;
    idx_nxt = idx_r;
    ent_nxt = ent_r;
    set_nxt = set_r;
    set_ch_nxt = set_ch_r;
    per_nxt = per_r;
    ph_nxt = ph_r;
    lvl_nxt = lvl_r;
    col_nxt = col_r;
    ovalid_nxt = ovalid_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = '0;
    raddr = idx_r;
    dreq = '0;
    in_ch.ready = 1'b0;
    unique case (state_r)
      lcpr_pkg::ST_CLEAR: begin
        we = 1'b1;
        idx_nxt = idx_r + 3'd1;
      end
      lcpr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        raddr = in_ch.channel;
        idx_nxt = '0;
        if (in_ch.valid) begin
          if (in_ch.operation == lcpr_pkg::OP_SET) begin
            set_ch_nxt = in_ch.channel;
            set_nxt.color = in_ch.color;
            set_nxt.mode = lcpr_pkg::mode_t'(in_ch.mode);
            set_nxt.on_time = in_ch.on_time;
            set_nxt.off_time = in_ch.off_time;
            set_nxt.anchor = now_r;
          end else begin
            now_nxt = now_r + MW'(1);
            if (since + MW'(1) >= {16'd0, period_cfg_r}) last_nxt = now_r + MW'(1);
          end
        end
      end
      lcpr_pkg::ST_SET_RD: begin
        raddr = set_ch_r;
      end
      lcpr_pkg::ST_SET_WR: begin
        waddr = set_ch_r;
        wdata = set_r;
        we = (rdata.color != set_r.color) || (rdata.mode != set_r.mode) ||
             (rdata.on_time != set_r.on_time) || (rdata.off_time != set_r.off_time);
      end
      lcpr_pkg::ST_RD: ;
      lcpr_pkg::ST_DIV: ;
      default: ;
    endcase
    // Launch and finish of the divider passes.
    if (start_r) begin
      ent_nxt = rdata;
      unique case (rdata.mode)
        lcpr_pkg::MODE_BLINK: per_nxt = (blink_per == '0) ? TW'(1) : blink_per;
        lcpr_pkg::MODE_PULSE:
          per_nxt = (rdata.on_time == '0) ? lcpr_pkg::PulseDefault : rdata.on_time;
        default: per_nxt = TW'(1);
      endcase
      dreq.start = 1'b1;
      dreq.num = age;
      dreq.den = per_nxt;
    end
    if (state_r == lcpr_pkg::ST_DIV && drsp.done) begin
      col_nxt = '0;
      if (ent_r.mode == lcpr_pkg::MODE_STEADY) col_nxt = ent_r.color;
      else if (ent_r.mode == lcpr_pkg::MODE_BLINK)
        col_nxt = (drsp.rem < ent_r.on_time) ? ent_r.color : 24'd0;
      ph_nxt = drsp.rem;
      ovalid_nxt = (ent_r.mode != lcpr_pkg::MODE_PULSE);
    end
    if (state_r == lcpr_pkg::ST_PULSE) begin
      dreq.start = 1'b1;
      dreq.num = MW'(pnum);
      dreq.den = per_r;
    end
    if (state_r == lcpr_pkg::ST_DIV2 && drsp.done) begin
      lvl_nxt = (ph_r < half) ? drsp.quot[7:0] : 8'd255 - drsp.quot[7:0];
      col_nxt = ent_r.color;
    end
    if (state_r == lcpr_pkg::ST_SCALE) begin
      col_nxt = {div255(prod_r), div255(prod_g), div255(prod_b)};
      ovalid_nxt = 1'b1;
    end
    if (state_r == lcpr_pkg::ST_OUT && ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
      idx_nxt = idx_r + 3'd1;
    end
    out_ch.valid = ovalid_r;
    out_ch.led_index = idx_r;
    out_ch.led_color = col_r;
    out_ch.last_in_frame = (idx_r == 3'(lcpr_pkg::NumChannels - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcpr_pkg::ST_CLEAR;
      period_cfg_r <= lcpr_pkg::FramePeriodRst;
      now_r <= '0;
      last_r <= '0;
      idx_r <= '0;
      ovalid_r <= 1'b0;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) period_cfg_r <= cfg_wdata;
      now_r <= now_nxt;
      last_r <= last_nxt;
      idx_r <= idx_nxt;
      ovalid_r <= ovalid_nxt;
      start_r <= (state_r == lcpr_pkg::ST_RD);
    end
    ent_r <= ent_nxt;
    set_r <= set_nxt;
    set_ch_r <= set_ch_nxt;
    per_r <= per_nxt;
    ph_r <= ph_nxt;
    lvl_r <= lvl_nxt;
    col_r <= col_nxt;
  end
endmodule

// File: rtl/lcpr_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// Stands alone.
module lcpr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/lcpr_div.sv
// Restoring divider, one quotient bit a cycle: 32-bit numerator, 16-bit divisor.
// Depends on lcpr_pkg.
module lcpr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lcpr_pkg::div_req_t req,
  output lcpr_pkg::div_rsp_t rsp
);
  logic [lcpr_pkg::MsW-1:0]   q_r, q_nxt;
  logic [lcpr_pkg::TimeW:0]   rem_r, rem_nxt;
  logic [lcpr_pkg::TimeW-1:0] den_r, den_nxt;
  logic [5:0]                 cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt, done_r, done_nxt;
  logic [lcpr_pkg::TimeW:0]   trial;
  logic [lcpr_pkg::TimeW+1:0] diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[lcpr_pkg::TimeW-1:0], q_r[lcpr_pkg::MsW-1]};
    diff = {1'b0, trial} - {2'b00, den_r};
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so 17 bits hold the trial.
      if (!diff[lcpr_pkg::TimeW+1]) begin
        rem_nxt = diff[lcpr_pkg::TimeW:0];
        q_nxt = {q_r[lcpr_pkg::MsW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[lcpr_pkg::MsW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = rem_r[lcpr_pkg::TimeW-1:0];
endmodule
